### sv/rlpd_pkg.sv
// Shared types, constants and helpers for the RLP stream decoder.
`timescale 1ns / 1ps
`default_nettype none
package rlpd_pkg;

	localparam int MAX_DEPTH = 8;
	localparam int POS_W = 64;
	localparam int CNT_RAW_W = $clog2(MAX_DEPTH + 2);
	localparam int CNT_W = (CNT_RAW_W < 5) ? 5 : CNT_RAW_W;

	localparam int IN_DATA_W = 8;
	localparam int IN_USER_W = 1;
	localparam int OUT_DATA_W = 80;
	localparam int OUT_USER_W = 3;

	localparam logic [7:0] PFX_BYTES = 8'h80;
	localparam logic [7:0] PFX_LIST = 8'hc0;
	localparam logic [5:0] SHORT_LIMIT = 6'd55;

	typedef enum logic [2:0] {
		PH_PREFIX  = 3'b001,
		PH_LENGTH  = 3'b010,
		PH_PAYLOAD = 3'b100
	} phase_t;

	typedef enum logic [2:0] {
		K_SINGLE  = 3'd0,
		K_STRING  = 3'd1,
		K_LIST    = 3'd2,
		K_LENGTH  = 3'd3,
		K_PAYLOAD = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_DEPTH   = 2'd1,
		ERR_OVERRUN = 2'd2
	} err_t;

	// broadcast to every stack cell
	typedef struct packed {
		logic             step;
		logic             clear;
		logic             push;
		logic [POS_W-1:0] next_pos;
		logic [POS_W-1:0] push_end;
	} cell_ctrl_t;

	typedef struct packed {
		logic             held;
		logic             valid;
		logic             top;
		logic             pop;
		logic [POS_W-1:0] end_pos;
	} cell_stat_t;

	function automatic logic [3:0] sat15(input logic [CNT_W-1:0] v);
		return (v > CNT_W'(15)) ? 4'd15 : v[3:0];
	endfunction

endpackage
`default_nettype wire

### sv/rlpd_cell.sv
// One entry of the list end stack: holds an end position, compares it and pops in chain.
`timescale 1ns / 1ps
`default_nettype none
module rlpd_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rlpd_pkg::cell_ctrl_t ctrl,
	input  wire logic                below_valid,
	input  wire logic                above_valid,
	input  wire logic                above_pop,
	output rlpd_pkg::cell_stat_t     stat
);
	import rlpd_pkg::*;

	logic             valid_q;
	logic [POS_W-1:0] end_q;
	logic             eff_valid;
	logic             match;
	logic             pop;
	logic             push_here;

	// a frame start empties the stack before this word is looked at
	assign eff_valid = valid_q & ~ctrl.clear;
	assign match     = eff_valid && (end_q == ctrl.next_pos);
	// pops run down from the top while ends keep matching; a pushing word
	// never has a matching top, so the chain stays idle then
	assign pop       = match && (!above_valid || above_pop);
	assign push_here = ctrl.push && !eff_valid && below_valid;

	assign stat.held    = valid_q;
	assign stat.valid   = eff_valid;
	assign stat.top     = eff_valid & ~above_valid;
	assign stat.pop     = pop;
	assign stat.end_pos = end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.step) begin
			valid_q <= push_here | (eff_valid & ~pop);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step && push_here) begin
			end_q <= ctrl.push_end;
		end
	end

endmodule
`default_nettype wire

### sv/rlpd_out_reg.sv
// Output register of the decoder: holds one result word until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none
module rlpd_out_reg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              load_valid,
	input  wire logic [rlpd_pkg::OUT_DATA_W-1:0]   load_data,
	input  wire logic [rlpd_pkg::OUT_USER_W-1:0]   load_user,
	output logic                                   load_ready,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [rlpd_pkg::OUT_DATA_W-1:0]        m_tdata,
	output logic [rlpd_pkg::OUT_USER_W-1:0]        m_tuser
);
	import rlpd_pkg::*;

	logic                  valid_q;
	logic [OUT_DATA_W-1:0] data_q;
	logic [OUT_USER_W-1:0] user_q;
	logic                  load;

	assign load_ready = ~valid_q | m_tready;
	assign load       = load_valid & load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ready) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
			user_q <= load_user;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;

endmodule
`default_nettype wire

### sv/rlp_stream_decoder.sv
// RLP stream decoder top level: prefix parser, chain of stack cells and output register.
//
// Input word: s_axis_tdata carries one byte of an RLP encoding, s_axis_tuser
// flags a frame start (parser and list stack are cleared before that byte,
// which then opens a new top-level item). Every accepted byte gives exactly
// one result word on the m_axis side: its byte kind in m_axis_tuser and the
// decoded length, nesting depth, closed list count, item end flag and error
// code in m_axis_tdata.
// A result word is registered when its byte is accepted. One byte is taken
// in every cycle while result words move. The cycle is set by the overrun check
// against the top of the stack and the push decision, with the end compare in
// every cell and the pop chain that runs down the cells alongside it.
// Reset (arst_n low) empties the stack and the output register and puts the
// parser back to expecting a prefix. While the receiver stalls the result is
// held and s_axis_tready drops only when the held result is not being taken,
// so the block keeps going as long as the result word moves.
`timescale 1ns / 1ps
`default_nettype none
module rlp_stream_decoder (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// [7:0] in_byte
	input  wire logic [rlpd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// [0] frame_start
	input  wire logic [rlpd_pkg::IN_USER_W-1:0]    s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// [63:0] item_length, [64] length_ready, [68:65] nest_depth,
	// [72:69] lists_closed, [73] item_done, [75:74] error_code, [79:76] zero
	output logic [rlpd_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
	// [2:0] byte_kind
	output logic [rlpd_pkg::OUT_USER_W-1:0]        m_axis_tuser
);
	import rlpd_pkg::*;

	phase_t           phase_q;
	logic [63:0]      acc_q;
	logic [3:0]       left_q;
	logic             is_list_q;
	logic [POS_W-1:0] next_q;
	logic [POS_W-1:0] str_end_q;

	logic             s_fire;
	logic             frame;
	logic [7:0]       b;

	phase_t           cur_phase;
	logic [63:0]      cur_acc;
	logic [3:0]       cur_left;
	logic             cur_list;
	logic [POS_W-1:0] cur_next;
	logic [POS_W-1:0] cur_str_end;

	phase_t           phase_n;
	logic [63:0]      acc_n;
	logic [3:0]       left_n;
	logic             list_n;
	logic [POS_W-1:0] str_end_n;

	kind_t            kind;
	err_t             err;
	logic [63:0]      len;
	logic             ready;
	logic             done;
	logic             open_str;
	logic             open_list;
	logic             empty_list;
	logic             push_req;
	logic [POS_W-1:0] push_end;
	logic [CNT_W-1:0] closed_cnt;
	logic [CNT_W-1:0] depth_cnt;

	cell_ctrl_t       ctrl;
	cell_stat_t       stat [MAX_DEPTH];
	logic [MAX_DEPTH-1:0] vld;
	logic [MAX_DEPTH-1:0] held;
	logic [MAX_DEPTH-1:0] pop_v;
	logic [MAX_DEPTH-1:0] below_v;
	logic [MAX_DEPTH-1:0] above_v;
	logic [MAX_DEPTH-1:0] above_p;
	logic [POS_W-1:0] top_end;
	logic             any_open;
	logic             full;

	logic [OUT_DATA_W-1:0] res_data;
	logic [OUT_USER_W-1:0] res_user;

	assign s_fire = s_axis_tvalid & s_axis_tready;
	assign frame  = s_axis_tuser[0];
	assign b      = s_axis_tdata;

	// state as seen by this byte: a frame start means reset values
	always_comb begin
		cur_phase   = frame ? PH_PREFIX : phase_q;
		cur_acc     = frame ? 64'd0 : acc_q;
		cur_left    = frame ? 4'd0 : left_q;
		cur_list    = frame ? 1'b0 : is_list_q;
		cur_next    = frame ? POS_W'(1) : next_q;
		cur_str_end = frame ? '0 : str_end_q;
	end

	// stack cells
	genvar gi;
	generate
		for (gi = 0; gi < MAX_DEPTH; gi++) begin : g_cell
			if (gi == 0) begin : g_bot
				assign below_v[gi] = 1'b1;
			end else begin : g_mid_b
				assign below_v[gi] = vld[gi-1];
			end
			if (gi == MAX_DEPTH - 1) begin : g_top
				assign above_v[gi] = 1'b0;
				assign above_p[gi] = 1'b0;
			end else begin : g_mid_a
				assign above_v[gi] = vld[gi+1];
				assign above_p[gi] = pop_v[gi+1];
			end
			rlpd_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (ctrl),
				.below_valid (below_v[gi]),
				.above_valid (above_v[gi]),
				.above_pop   (above_p[gi]),
				.stat        (stat[gi])
			);
			assign vld[gi]   = stat[gi].valid;
			assign held[gi]  = stat[gi].held;
			assign pop_v[gi] = stat[gi].pop;
		end
	endgenerate

	always_comb begin
		top_end = '0;
		for (int i = 0; i < MAX_DEPTH; i++) begin
			top_end = top_end | (stat[i].top ? stat[i].end_pos : '0);
		end
	end

	assign any_open = vld[0];
	assign full     = vld[MAX_DEPTH-1];

	assign ctrl.step     = s_fire;
	assign ctrl.clear    = frame;
	assign ctrl.push     = push_req;
	assign ctrl.next_pos = cur_next;
	assign ctrl.push_end = push_end;

	// prefix parse, overrun cut and phase update
	always_comb begin
		logic [POS_W-1:0] end_pos;
		logic [POS_W-1:0] room;
		kind       = K_SINGLE;
		err        = ERR_NONE;
		len        = '0;
		ready      = 1'b0;
		done       = 1'b0;
		open_str   = 1'b0;
		open_list  = 1'b0;
		empty_list = 1'b0;
		push_req   = 1'b0;
		push_end   = '0;
		phase_n    = cur_phase;
		acc_n      = cur_acc;
		left_n     = cur_left;
		list_n     = cur_list;
		str_end_n  = cur_str_end;

		case (cur_phase)
			PH_PREFIX: begin
				if (b < PFX_BYTES) begin
					kind  = K_SINGLE;
					len   = 64'd1;
					ready = 1'b1;
					done  = 1'b1;
				end else begin
					kind = (b < PFX_LIST) ? K_STRING : K_LIST;
					if (b[5:0] <= SHORT_LIMIT) begin
						len       = 64'(b[5:0]);
						ready     = 1'b1;
						open_str  = (b < PFX_LIST);
						open_list = ~(b < PFX_LIST);
					end else begin
						left_n  = 4'(b[5:0] - SHORT_LIMIT);
						acc_n   = '0;
						list_n  = ~(b < PFX_LIST);
						phase_n = PH_LENGTH;
					end
				end
			end
			PH_LENGTH: begin
				kind   = K_LENGTH;
				acc_n  = {cur_acc[55:0], b};
				left_n = (cur_left != 4'd0) ? cur_left - 4'd1 : 4'd0;
				if (left_n == 4'd0) begin
					len       = acc_n;
					ready     = 1'b1;
					open_str  = ~cur_list;
					open_list = cur_list;
					phase_n   = PH_PREFIX;
				end
			end
			PH_PAYLOAD: begin
				kind = K_PAYLOAD;
				if (cur_next == cur_str_end) begin
					done    = 1'b1;
					phase_n = PH_PREFIX;
				end
			end
			default: begin
				phase_n = PH_PREFIX;
			end
		endcase

		end_pos = cur_next + len;
		room    = top_end - cur_next;
		if ((open_str || open_list) && any_open && (len > room)) begin
			end_pos = top_end;
			err     = ERR_OVERRUN;
		end
		if (open_str) begin
			if (end_pos == cur_next) begin
				done    = 1'b1;
				phase_n = PH_PREFIX;
			end else begin
				str_end_n = end_pos;
				phase_n   = PH_PAYLOAD;
			end
		end
		if (open_list) begin
			if (end_pos == cur_next) begin
				empty_list = 1'b1;
			end else if (!full) begin
				push_req = 1'b1;
				push_end = end_pos;
			end else begin
				err = ERR_DEPTH;
			end
		end

		// an enclosing list ran out while an item was still open
		if ((|pop_v) && (phase_n != PH_PREFIX)) begin
			if (err == ERR_NONE) begin
				err = ERR_OVERRUN;
			end
			phase_n = PH_PREFIX;
			left_n  = 4'd0;
		end
	end

	assign closed_cnt = CNT_W'($countones(pop_v)) + CNT_W'(empty_list);
	assign depth_cnt  = CNT_W'($countones(vld));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_PREFIX;
			acc_q     <= '0;
			left_q    <= '0;
			is_list_q <= 1'b0;
			next_q    <= POS_W'(1);
			str_end_q <= '0;
		end else if (s_fire) begin
			phase_q   <= phase_n;
			acc_q     <= acc_n;
			left_q    <= left_n;
			is_list_q <= list_n;
			next_q    <= cur_next + POS_W'(1);
			str_end_q <= str_end_n;
		end
	end

	assign res_data = {4'd0, err, done, sat15(closed_cnt), sat15(depth_cnt), ready, len};
	assign res_user = kind;

	rlpd_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (s_axis_tvalid),
		.load_data  (res_data),
		.load_user  (res_user),
		.load_ready (s_axis_tready),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.m_tuser    (m_axis_tuser)
	);

	// open entries always sit at the bottom of the chain
	a_stack_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(held & (held + MAX_DEPTH'(1))) == '0)
		else $error("stack cells not contiguous");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && push_req |=> $countones(held) == $past($countones(vld)) + 1)
		else $error("push did not add exactly one entry");

	a_no_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |-> !(push_req && (|pop_v)))
		else $error("push and pop on the same word");

	a_pop_leaves_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && (|pop_v) |=> phase_q == PH_PREFIX)
		else $error("list closed but item still open");

endmodule
`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the RLP stream decoder: byte stimulus, predictor and scoreboard.
`timescale 1ns / 1ps
module tb_top;
	import rlpd_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 10;
	localparam int ITEM_TARGET   = 1700;
	localparam int MAX_GAP       = 18;
	localparam int HOLD_AFTER    = 900;
	localparam int HOLD_CYCLES   = 150;
	localparam int DRAIN_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS   = 30;
	localparam int TIMEOUT_NS    = 5_000_000;
	localparam int TX            = 0;
	localparam int RX            = 1;

	typedef logic [7:0] byte_q_t[$];
	typedef struct {
		logic [7:0] b;
		logic       fs;
	} stim_t;

	// {frame_start, byte}
	localparam logic [8:0] DIRECTED [25] = '{
		9'h100, 9'h07f, 9'h080, 9'h0c0,           // single byte extremes, empty string and list
		9'h1c2, 9'h081, 9'h055,                   // list holding a one-byte string
		9'h1c2, 9'h0b9, 9'h000,                   // list ends under a pending long header
		9'h1c1, 9'h082,                           // string overruns its list
		9'h1bf, 9'h0ff, 9'h0ff, 9'h0ff, 9'h0ff,   // largest long length, end wraps
		9'h0ff, 9'h0ff, 9'h0ff, 9'h0ff,
		9'h1f8, 9'h000,                           // long-form empty list
		9'h0b8, 9'h000                            // long-form empty string
	};

	class rlp_tracker;
		typedef struct {
			kind_t       kind;
			logic [63:0] len;
			logic        ready;
			logic [3:0]  depth;
			logic [3:0]  closed;
			logic        done;
			err_t        err;
		} byte_verdict_t;

		byte_verdict_t due_words[$];
		phase_t        phase;
		logic [63:0]   acc;
		logic [63:0]   pos;
		logic [63:0]   str_end;
		logic [3:0]    len_left;
		logic          hdr_list;
		logic [63:0]   ends [MAX_DEPTH];
		int            sp;
		int            mismatches;
		int            words_checked;
		int            depth_errs;
		int            overrun_errs;
		int            deepest;
		int            kinds_seen [5];

		function new();
			clear();
		endfunction

		function void clear();
			phase = PH_PREFIX;
			acc = '0;
			pos = '0;
			str_end = '0;
			len_left = '0;
			hdr_list = 1'b0;
			sp = 0;
			foreach (ends[i])
				ends[i] = '0;
		endfunction

		// accepted input byte: work out the word it must produce
		function void take_byte(input logic [7:0] b, input logic fs);
			byte_verdict_t v;
			logic [63:0]   nxt;
			logic [63:0]   ln;
			logic [63:0]   fin;
			logic [63:0]   top;
			logic [7:0]    base;
			bit            opens_str;
			bit            opens_list;
			bit            popped;
			int            closed;
			if (fs)
				clear();
			v.kind = K_SINGLE;
			v.ready = 1'b0;
			v.done = 1'b0;
			v.err = ERR_NONE;
			v.depth = 4'(sp);
			nxt = pos + 64'd1;
			ln = '0;
			closed = 0;
			opens_str = 1'b0;
			opens_list = 1'b0;
			popped = 1'b0;
			case (phase)
				PH_PREFIX: begin
					if (b < PFX_BYTES) begin
						ln = 64'd1;
						v.ready = 1'b1;
						v.done = 1'b1;
					end else begin
						v.kind = (b < PFX_LIST) ? K_STRING : K_LIST;
						base = (b < PFX_LIST) ? PFX_BYTES : PFX_LIST;
						if (b - base <= 8'(SHORT_LIMIT)) begin
							ln = 64'(b - base);
							v.ready = 1'b1;
							opens_str = (b < PFX_LIST);
							opens_list = !opens_str;
						end else begin
							len_left = 4'(b - base - 8'(SHORT_LIMIT));
							acc = '0;
							hdr_list = (b >= PFX_LIST);
							phase = PH_LENGTH;
						end
					end
				end
				PH_LENGTH: begin
					v.kind = K_LENGTH;
					acc = {acc[55:0], b};
					if (len_left != 0)
						len_left--;
					if (len_left == 0) begin
						ln = acc;
						v.ready = 1'b1;
						opens_list = hdr_list;
						opens_str = !hdr_list;
						phase = PH_PREFIX;
					end
				end
				default: begin
					v.kind = K_PAYLOAD;
					if (nxt == str_end) begin
						v.done = 1'b1;
						phase = PH_PREFIX;
					end
				end
			endcase

			if (opens_str || opens_list) begin
				fin = nxt + ln;
				if (sp > 0) begin
					top = ends[sp-1];
					// item reaching past the enclosing list is cut to its end
					if (ln > top - nxt) begin
						fin = top;
						v.err = ERR_OVERRUN;
					end
				end
				if (opens_str) begin
					if (fin == nxt) begin
						v.done = 1'b1;
						phase = PH_PREFIX;
					end else begin
						str_end = fin;
						phase = PH_PAYLOAD;
					end
				end else if (fin == nxt)
					closed++;
				else if (sp < MAX_DEPTH) begin
					ends[sp] = fin;
					sp++;
				end else
					v.err = ERR_DEPTH;
			end

			while (sp > 0 && ends[sp-1] == nxt) begin
				sp--;
				closed++;
				popped = 1'b1;
			end
			// list closed mid-item: drop what was pending
			if (popped && phase != PH_PREFIX) begin
				if (v.err == ERR_NONE)
					v.err = ERR_OVERRUN;
				phase = PH_PREFIX;
				len_left = '0;
			end
			pos = nxt;

			v.len = v.ready ? ln : '0;
			v.closed = (closed > 15) ? 4'd15 : 4'(closed);
			kinds_seen[v.kind]++;
			if (v.err == ERR_DEPTH)
				depth_errs++;
			if (v.err == ERR_OVERRUN)
				overrun_errs++;
			if (v.depth > deepest)
				deepest = v.depth;
			due_words.push_back(v);
		endfunction

		function void compare(input string what, input logic [63:0] want, input logic [63:0] got);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: word %0d %s expected %h, got %h",
						$time, words_checked, what, want, got);
			end
		endfunction

		function void match_word(input logic [OUT_DATA_W-1:0] d, input logic [OUT_USER_W-1:0] u);
			byte_verdict_t v;
			words_checked++;
			if (due_words.size() == 0) begin
				mismatches++;
				$display("%0t: word %0d with nothing outstanding, expected none, got tdata=%h tuser=%h",
					$time, words_checked, d, u);
				return;
			end
			v = due_words.pop_front();
			compare("byte_kind", 64'(v.kind), 64'(u[2:0]));
			compare("item_length", v.len, d[63:0]);
			compare("length_ready", 64'(v.ready), 64'(d[64]));
			compare("nest_depth", 64'(v.depth), 64'(d[68:65]));
			compare("lists_closed", 64'(v.closed), 64'(d[72:69]));
			compare("item_done", 64'(v.done), 64'(d[73]));
			compare("error_code", 64'(v.err), 64'(d[75:74]));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_USER_W-1:0]  s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;

	rlp_tracker tracker;
	stim_t      stim_q[$];
	int         run_left [2];
	bit         calm [2];
	bit         rx_hold;
	bit         held_off;

	rlp_stream_decoder i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// idle cycles before the next word; runs of busy and quiet stretches per side
	function automatic int next_gap(input int side);
		if (run_left[side] == 0) begin
			run_left[side] = $urandom_range(10, 150);
			calm[side] = ($urandom_range(0, 3) == 0);
		end
		run_left[side]--;
		return calm[side] ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	function automatic void add_byte(input logic [7:0] b, input logic fs);
		stim_t s;
		s.b = b;
		s.fs = fs;
		stim_q.push_back(s);
	endfunction

	// one well-formed top-level item, built depth first with a body per open level
	function automatic byte_q_t build_frame(input bit deep, input int budget);
		byte_q_t     body [13];
		int          kids_left [13];
		logic [7:0]  lvl_base [13];
		int          lvl;
		int          r;
		int          n;
		int          nb;
		bit          padded;
		logic [63:0] plen;
		logic [63:0] v;
		lvl = 0;
		kids_left[0] = 1;
		forever begin
			if (kids_left[lvl] == 0) begin
				if (lvl == 0)
					break;
				plen = 64'(body[lvl].size());
				nb = 0;
				v = plen;
				while (v != 0) begin
					nb++;
					v = v >> 8;
				end
				padded = ($urandom_range(0, 9) == 0);
				if (plen <= 64'(SHORT_LIMIT) && !padded)
					body[lvl-1].push_back(lvl_base[lvl] + plen[7:0]);
				else begin
					// padded lengths carry a leading zero byte
					if ((padded || nb == 0) && nb < 8)
						nb++;
					body[lvl-1].push_back(lvl_base[lvl] + 8'(SHORT_LIMIT) + 8'(nb));
					for (int i = nb - 1; i >= 0; i--)
						body[lvl-1].push_back(8'(plen >> (8 * i)));
				end
				for (int j = 0; j < body[lvl].size(); j++)
					body[lvl-1].push_back(body[lvl][j]);
				lvl--;
				continue;
			end
			kids_left[lvl]--;
			budget--;
			r = $urandom_range(0, 99);
			if (budget > 0 && lvl < 11 && (deep ? r < 85 : (lvl < 5 && r < 30))) begin
				lvl++;
				body[lvl].delete();
				lvl_base[lvl] = PFX_LIST;
				kids_left[lvl] = deep ? $urandom_range(1, 2) : $urandom_range(0, 4);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 30)
					body[lvl].push_back(8'($urandom_range(0, 127)));
				else begin
					n = (r < 40) ? 0 : (r < 85) ? $urandom_range(1, 20) :
						(r < 95) ? $urandom_range(21, 55) : $urandom_range(56, 160);
					lvl++;
					body[lvl].delete();
					lvl_base[lvl] = PFX_BYTES;
					kids_left[lvl] = 0;
					repeat (n)
						body[lvl].push_back(8'($urandom));
				end
			end
		end
		return body[0];
	endfunction

	task automatic send_byte(input stim_t it);
		int gap;
		gap = rx_hold ? 0 : next_gap(TX);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata <= it.b;
		s_axis_tuser <= it.fs;
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (s_axis_tready !== 1'b1);
		tracker.take_byte(it.b, it.fs);
	endtask

	initial begin : stimulus
		byte_q_t frame;
		int      r;
		int      cut;
		int      nlen;
		int      waited;
		bit      fs_first;
		bit      deep;
		tracker = new();
		foreach (DIRECTED[i])
			add_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
		while (stim_q.size() < ITEM_TARGET) begin
			deep = ($urandom_range(0, 99) < 15);
			frame = build_frame(deep, deep ? 30 : $urandom_range(3, 25));
			r = $urandom_range(0, 99);
			if (r >= 64 && r < 74) begin
				cut = $urandom_range(0, frame.size() - 1);
				frame = frame[0:cut];
			end else if (r >= 74 && r < 86)
				frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
			else if (r >= 86 && r < 93) begin
				// long header with arbitrary length bytes, sometimes inside a short list
				frame.delete();
				nlen = $urandom_range(1, 8);
				frame.push_back(($urandom_range(0, 1) ? PFX_LIST : PFX_BYTES) +
					8'(SHORT_LIMIT) + 8'(nlen));
				repeat (nlen + $urandom_range(0, 6))
					frame.push_back(8'($urandom));
				if ($urandom_range(0, 1))
					frame.push_front(PFX_LIST + 8'($urandom_range(1, 12)));
			end else if (r >= 93) begin
				frame.delete();
				repeat ($urandom_range(1, 10))
					frame.push_back(8'($urandom));
			end
			fs_first = ($urandom_range(0, 99) < 80);
			foreach (frame[j])
				add_byte(frame[j], (j == 0) ? fs_first : (r >= 93 && $urandom_range(0, 7) == 0));
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (stim_q[i])
			send_byte(stim_q[i]);
		s_axis_tvalid <= 1'b0;

		waited = 0;
		while (tracker.due_words.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.due_words.size() != 0) begin
			$display("%0t: %0d result words never arrived", $time, tracker.due_words.size());
			tracker.mismatches += tracker.due_words.size();
		end

		$display("%0d bytes: %0d single, %0d string hdr, %0d list hdr, %0d length, %0d payload",
			stim_q.size(), tracker.kinds_seen[K_SINGLE], tracker.kinds_seen[K_STRING],
			tracker.kinds_seen[K_LIST], tracker.kinds_seen[K_LENGTH],
			tracker.kinds_seen[K_PAYLOAD]);
		$display("depth errors %0d, overruns %0d, deepest nesting %0d, %0d-cycle hold-off, %0d mismatches",
			tracker.depth_errs, tracker.overrun_errs, tracker.deepest, HOLD_CYCLES,
			tracker.mismatches);
		if (tracker.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin : receiver
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held_off && tracker.words_checked >= HOLD_AFTER) begin
				// long stall so the output fills and the input backs up
				held_off = 1'b1;
				rx_hold = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
			end else begin
				gap = next_gap(RX);
				if (gap > 0) begin
					m_axis_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			do
				@(posedge clk);
			while (m_axis_tvalid !== 1'b1);
			tracker.match_word(m_axis_tdata, m_axis_tuser);
		end
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("timeout with %0d result words outstanding", tracker.due_words.size());
		$display("simulation failed");
		$finish;
	end

endmodule

### sim.f
sv/rlpd_pkg.sv
sv/rlpd_cell.sv
sv/rlpd_out_reg.sv
sv/rlp_stream_decoder.sv
sim/tb_top.sv
